[hw/rtl/ced_pkg.sv]
// Package of the C escape decoder: decode phases, character constants,
// the escape letter table and the result bundle passed to the output queue.
// No dependencies.
`default_nettype none

package ced_pkg;

	typedef enum logic [1:0] {
		PH_TEXT   = 2'd0,
		PH_ESCAPE = 2'd1,
		PH_OCTAL  = 2'd2,
		PH_SPARE  = 2'd3
	} phase_t;

	localparam logic [7:0] ESC_CHAR       = 8'h5C;
	localparam logic [7:0] OCT_ZERO       = 8'h30;
	localparam logic [7:0] OCT_SEVEN      = 8'h37;
	localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

	typedef struct packed {
		logic [1:0] count;
		logic [7:0] res0;
		logic [7:0] res1;
	} dec_res_t;

	function automatic logic [7:0] escape_letter(input logic [7:0] b);
		logic [7:0] r;
		unique case (b)
			8'h61: r = 8'd7;
			8'h62: r = 8'd8;
			8'h66: r = 8'd12;
			8'h6E: r = 8'd10;
			8'h72: r = 8'd13;
			8'h74: r = 8'd9;
			8'h76: r = 8'd11;
			default: r = b;
		endcase
		return r;
	endfunction

	function automatic logic is_octal(input logic [7:0] b);
		return (b >= OCT_ZERO) && (b <= OCT_SEVEN);
	endfunction

endpackage

`default_nettype wire

[hw/rtl/ced_decode.sv]
// Decode step of the C escape decoder: holds the phase and octal run state
// and turns one registered word into zero to two result bytes.
// Depends on ced_pkg.
`default_nettype none

module ced_decode (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [7:0]      in_byte,
	input  wire logic            is_final,
	output ced_pkg::dec_res_t    res
);

	ced_pkg::phase_t phase_q, phase_d;
	logic [7:0] oval_q, oval_d;
	logic [1:0] odig_q, odig_d;
	logic       plain;
	logic       oct;
	logic [2:0] digit;
	logic [7:0] nval;
	logic [1:0] ndig;

	assign oct   = ced_pkg::is_octal(in_byte);
	assign digit = in_byte[2:0];
	assign nval  = {oval_q[4:0], digit};
	assign ndig  = odig_q + 2'd1;

	always_comb begin
		phase_d   = ced_pkg::PH_TEXT;
		oval_d    = oval_q;
		odig_d    = odig_q;
		plain     = 1'b0;
		res.count = 2'd0;
		res.res0  = 8'd0;
		res.res1  = 8'd0;
		unique case (phase_q)
			ced_pkg::PH_ESCAPE: begin
				if (oct) begin
					oval_d = {5'd0, digit};
					odig_d = 2'd1;
					if (is_final) begin
						res.count = 2'd1;
						res.res0  = {5'd0, digit};
					end else begin
						phase_d = ced_pkg::PH_OCTAL;
					end
				end else begin
					res.count = 2'd1;
					res.res0  = ced_pkg::escape_letter(in_byte);
				end
			end
			ced_pkg::PH_OCTAL: begin
				if (oct) begin
					oval_d = nval;
					odig_d = ndig;
					if ((ndig >= ced_pkg::OCT_MAX_DIGITS) || is_final) begin
						res.count = 2'd1;
						res.res0  = nval;
						oval_d    = 8'd0;
						odig_d    = 2'd0;
					end else begin
						phase_d = ced_pkg::PH_OCTAL;
					end
				end else begin
					res.count = 2'd1;
					res.res0  = oval_q;
					oval_d    = 8'd0;
					odig_d    = 2'd0;
					plain     = 1'b1;
				end
			end
			default: begin
				plain = 1'b1;
			end
		endcase
		if (plain) begin
			if (in_byte == ced_pkg::ESC_CHAR) begin
				if (!is_final) begin
					phase_d = ced_pkg::PH_ESCAPE;
				end
			end else if (res.count == 2'd0) begin
				res.count = 2'd1;
				res.res0  = in_byte;
			end else begin
				res.count = 2'd2;
				res.res1  = in_byte;
			end
		end
		if (is_final) begin
			phase_d = ced_pkg::PH_TEXT;
			oval_d  = 8'd0;
			odig_d  = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ced_pkg::PH_TEXT;
			oval_q  <= 8'd0;
			odig_q  <= 2'd0;
		end else if (step) begin
			phase_q <= phase_d;
			oval_q  <= oval_d;
			odig_q  <= odig_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ced_outq.sv]
// Four-entry result queue of the C escape decoder: takes up to two bytes
// per cycle from the decode step and hands them out one word at a time.
// Depends on ced_pkg.
`default_nettype none

module ced_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ced_pkg::dec_res_t res,
	output logic                   room,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             out_byte,
	output logic                   run_last
);

	logic [8:0] mem_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;
	logic [1:0] pn;
	logic       pop;

	assign pn        = push ? res.count : 2'd0;
	assign pop       = out_valid && out_ready;
	assign room      = cnt_q <= 3'd2;
	assign out_valid = cnt_q != 3'd0;
	assign out_byte  = mem_q[rp_q][8:1];
	assign run_last  = mem_q[rp_q][0];

	always_ff @(posedge clk) begin
		if (pn != 2'd0) begin
			mem_q[wp_q] <= {res.res0, pn == 2'd1};
		end
		if (pn == 2'd2) begin
			mem_q[wp_q + 2'd1] <= {res.res1, 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wp_q  <= wp_q + pn;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, pn} - {2'b00, pop};
		end
	end

endmodule

`default_nettype wire

[hw/rtl/c_escape_decoder.sv]
// Top level of the C escape decoder: input register, decode step and
// result queue. Depends on ced_pkg, ced_decode and ced_outq.
//
// Usage: text bytes enter on the in_valid/in_ready channel with is_final
// set on the last byte of each string. Decoded bytes leave on the
// out_valid/out_ready channel; run_last marks the last decoded byte that
// one input word produced. An input word gives zero, one or two results.
// One input word is taken per cycle while the receiver keeps up; the
// output drains one word per cycle while out_ready is high, so a word
// that yields two results takes two output transfers. A four-entry
// result queue sits between the decode step and the output, and the
// registered word is decoded only when the queue has room for two
// results; a stalled receiver therefore fills the queue and then holds
// in_ready low without losing anything.
// Reset clears the decode phase, the octal run and the queue.
`default_nettype none

module c_escape_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       is_final,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            run_last
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              final_s1;
	logic              room;
	logic              step;
	ced_pkg::dec_res_t res;

	assign step     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= in_byte;
			final_s1 <= is_final;
		end
	end

	ced_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.in_byte  (byte_s1),
		.is_final (final_s1),
		.res      (res)
	);

	ced_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.res       (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for c_escape_decoder: random and directed escaped strings,
// with a scoreboard class that predicts the decoded words and checks them in order.
// Depends on ced_pkg and the c_escape_decoder RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 1600;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 300;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} dec_word_t;

	class unescape_scoreboard;
		dec_word_t       awaited_q[$];
		ced_pkg::phase_t phase;
		logic [7:0]      oct_acc;
		logic [1:0]      oct_cnt;
		int              errors;
		int              words_in;
		int              words_out;

		function new();
			phase = ced_pkg::PH_TEXT;
			oct_acc = '0;
			oct_cnt = '0;
			errors = 0;
			words_in = 0;
			words_out = 0;
		endfunction

		function int pending();
			return awaited_q.size();
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= MAX_REPORTS) begin
				$display("[%0t] MISMATCH: %s", $realtime, msg);
			end
		endfunction

		function void note_input(logic [7:0] b, logic fin);
			logic [7:0] vals[2];
			int         n;
			logic       plain;
			logic       is_digit;
			dec_word_t  w;
			n = 0;
			plain = 1'b0;
			is_digit = (b >= ced_pkg::OCT_ZERO) && (b <= ced_pkg::OCT_SEVEN);
			words_in++;
			case (phase)
				ced_pkg::PH_ESCAPE: begin
					if (is_digit) begin
						oct_acc = b - ced_pkg::OCT_ZERO;
						oct_cnt = 2'd1;
						if (fin) begin
							vals[n++] = oct_acc;
							phase = ced_pkg::PH_TEXT;
						end else begin
							phase = ced_pkg::PH_OCTAL;
						end
					end else begin
						case (b)
							"a": vals[n] = 8'd7;
							"b": vals[n] = 8'd8;
							"f": vals[n] = 8'd12;
							"n": vals[n] = 8'd10;
							"r": vals[n] = 8'd13;
							"t": vals[n] = 8'd9;
							"v": vals[n] = 8'd11;
							default: vals[n] = b;
						endcase
						n++;
						phase = ced_pkg::PH_TEXT;
					end
				end
				ced_pkg::PH_OCTAL: begin
					if (is_digit) begin
						oct_acc = {oct_acc[4:0], 3'b000} + (b - ced_pkg::OCT_ZERO);
						oct_cnt = oct_cnt + 2'd1;
						if (oct_cnt >= ced_pkg::OCT_MAX_DIGITS || fin) begin
							vals[n++] = oct_acc;
							oct_acc = '0;
							oct_cnt = '0;
							phase = ced_pkg::PH_TEXT;
						end
					end else begin
						vals[n++] = oct_acc;
						oct_acc = '0;
						oct_cnt = '0;
						phase = ced_pkg::PH_TEXT;
						plain = 1'b1;
					end
				end
				default: begin
					phase = ced_pkg::PH_TEXT;
					plain = 1'b1;
				end
			endcase
			if (plain) begin
				if (b == ced_pkg::ESC_CHAR) begin
					if (!fin) begin
						phase = ced_pkg::PH_ESCAPE;
					end
				end else begin
					vals[n++] = b;
				end
			end
			if (fin) begin
				phase = ced_pkg::PH_TEXT;
				oct_acc = '0;
				oct_cnt = '0;
			end
			for (int k = 0; k < n; k++) begin
				w.value = vals[k];
				w.last = (k == n - 1);
				awaited_q.push_back(w);
			end
		endfunction

		function void check_result(logic [7:0] v, logic last);
			dec_word_t w;
			words_out++;
			if (awaited_q.size() == 0) begin
				report($sformatf("unexpected word out_byte=%02h run_last=%0b", v, last));
				return;
			end
			w = awaited_q.pop_front();
			if (w.value !== v || w.last !== last) begin
				report($sformatf("expected out_byte=%02h run_last=%0b, got out_byte=%02h run_last=%0b",
					w.value, w.last, v, last));
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = '0;
	logic       is_final = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;

	unescape_scoreboard sb = new();
	logic [7:0]         text_q[$];
	string              esc_letters = "abfnrtv";
	int                 words_sent = 0;
	int                 strings_sent = 0;
	int                 burst_left = 0;
	int                 holds_asked = 0;
	int                 holds_done = 0;
	int                 cycle_cnt = 0;

	c_escape_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.is_final (is_final),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.run_last (run_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_input(in_byte, is_final);
			end
			if (out_valid && out_ready) begin
				sb.check_result(out_byte, run_last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d words outstanding", cycle_cnt, sb.pending());
			$display("c_escape_decoder test failed");
			$finish;
		end
	end

	initial begin : receiver
		int seg;
		int mode;
		forever begin
			seg = $urandom_range(10, 150);
			mode = $urandom_range(0, 3);
			for (int k = 0; k < seg; k++) begin
				@(posedge clk);
				if (holds_done != holds_asked) begin
					out_ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
					holds_done++;
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= k[2];
				endcase
			end
		end
	end

	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 12);
		end
		burst_left--;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++) begin
			pace();
			in_valid <= 1'b1;
			in_byte <= text_q[i];
			is_final <= (i == text_q.size() - 1);
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			words_sent++;
		end
		strings_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	function automatic void load_text(string s);
		text_q.delete();
		for (int i = 0; i < s.len(); i++) begin
			text_q.push_back(s[i]);
		end
	endfunction

	function automatic void build_random_text();
		int tokens;
		int kind;
		int digits;
		text_q.delete();
		tokens = $urandom_range(1, 6);
		repeat (tokens) begin
			kind = $urandom_range(0, 9);
			if (kind >= 4) begin
				text_q.push_back(ced_pkg::ESC_CHAR);
			end
			case (kind)
				0, 1, 8: text_q.push_back(8'($urandom_range(0, 255)));
				2, 3: text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
				4, 5: text_q.push_back(esc_letters[$urandom_range(0, 6)]);
				6, 7: begin
					digits = $urandom_range(1, 4);
					repeat (digits) begin
						text_q.push_back(8'(ced_pkg::OCT_ZERO + $urandom_range(0, 7)));
					end
					if ($urandom_range(0, 3) == 0) begin
						text_q.push_back(8'(ced_pkg::OCT_SEVEN + $urandom_range(1, 2)));
					end
				end
				default: ;
			endcase
		end
	endfunction

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_text("\\a\\b\\f\\n\\r\\t\\v");
		send_text();
		load_text("\\777");
		send_text();
		load_text("\\12\\x");
		send_text();
		load_text("\\3");
		send_text();
		load_text("\\34");
		send_text();
		load_text("\\");
		send_text();
		text_q = '{8'h00, 8'hFF};
		send_text();

		while (words_sent < ITEM_TARGET) begin
			if (strings_sent == 30 || strings_sent == 140) begin
				holds_asked <= holds_asked + 1;
			end
			if (strings_sent % 70 == 69) begin
				drain();
			end
			build_random_text();
			send_text();
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d strings (%0d input words), checked %0d decoded words, %0d long holds.",
			strings_sent, sb.words_in, sb.words_out, holds_done);
		$display("Mismatches: %0d, words still outstanding: %0d", sb.errors, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("c_escape_decoder test passed");
		end else begin
			$display("c_escape_decoder test failed");
		end
		$finish;
	end
endmodule
